[rtl/core/xcrc_pkg.sv]
package xcrc_pkg;

  localparam int PAYLOAD_BYTES = 128;

  localparam logic [7:0]  SOH_CODE = 8'h01;
  localparam logic [7:0]  EOT_CODE = 8'h04;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  NUM_SUM  = 8'hff;

  localparam logic REQ_BYTE    = 1'b0;
  localparam logic REQ_TIMEOUT = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [2:0] {
    V_GOOD    = 3'd0,
    V_DUP     = 3'd1,
    V_END     = 3'd2,
    V_BAD     = 3'd3,
    V_LINE    = 3'd4,
    V_TIMEOUT = 3'd5
  } verdict_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
    logic       rx_error;
  } beat_t;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] data_byte;
    logic [6:0] byte_index;
    verdict_t   verdict;
    logic       send_nak;
  } result_t;

  function automatic logic nak_of(verdict_t v);
    return !(v == V_GOOD || v == V_DUP || v == V_END);
  endfunction

endpackage

[rtl/core/xcrc_crc16.sv]
module xcrc_crc16 (
  input  logic [15:0] crc,
  input  logic [7:0]  data,
  output logic [15:0] crc_next
);

  // msb-first fold of one byte, eight shift steps
  always_comb begin
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ xcrc_pkg::CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_next = c;
  end

endmodule

[rtl/core/xcrc_framer.sv]
module xcrc_framer #(
  parameter int PAYLOAD_BYTES = xcrc_pkg::PAYLOAD_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  xcrc_pkg::beat_t   beat,
  output xcrc_pkg::result_t res
);

  localparam int LAST_POS = PAYLOAD_BYTES + 4;
  localparam int POS_W    = $clog2(LAST_POS + 1);
  localparam logic [POS_W-1:0] POS_HI  = POS_W'(PAYLOAD_BYTES + 3);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(LAST_POS);

  logic [POS_W-1:0] pos, pos_next;
  logic [7:0]       block_number, block_number_next;
  logic [7:0]       block_complement, block_complement_next;
  logic [15:0]      running_crc, running_crc_next;
  logic [7:0]       crc_high_received, crc_high_received_next;
  logic [7:0]       last_good_number, last_good_number_next;
  logic             error_seen, error_seen_next;
  logic [15:0]      crc_fold;
  logic [POS_W-1:0] pay_pos;

  xcrc_crc16 u_crc (
    .crc      (running_crc),
    .data     (beat.rx_byte),
    .crc_next (crc_fold)
  );

  assign pay_pos = pos - POS_W'(3);

  // result is computed from the waiting beat and the framing state; en only commits the state
  always_comb begin
    logic              err;
    xcrc_pkg::verdict_t v;
    logic              close;
    pos_next               = pos;
    block_number_next      = block_number;
    block_complement_next  = block_complement;
    running_crc_next       = running_crc;
    crc_high_received_next = crc_high_received;
    last_good_number_next  = last_good_number;
    error_seen_next        = error_seen;
    res                    = '0;
    err                    = error_seen | beat.rx_error;
    v                      = xcrc_pkg::V_BAD;
    close                  = 1'b0;
    if (beat.req_type == xcrc_pkg::REQ_TIMEOUT) begin
      v     = xcrc_pkg::V_TIMEOUT;
      close = 1'b1;
    end else begin
      error_seen_next = err;
      priority if (pos == '0) begin
        if (beat.rx_byte != xcrc_pkg::SOH_CODE) begin
          close = 1'b1;
          if (err) begin
            v = xcrc_pkg::V_LINE;
          end else if (beat.rx_byte == xcrc_pkg::EOT_CODE) begin
            v = xcrc_pkg::V_END;
          end else begin
            v = xcrc_pkg::V_BAD;
          end
        end else begin
          pos_next = POS_W'(1);
        end
      end else if (pos == POS_W'(1)) begin
        block_number_next = beat.rx_byte;
        pos_next          = POS_W'(2);
      end else if (pos == POS_W'(2)) begin
        block_complement_next = beat.rx_byte;
        pos_next              = POS_W'(3);
      end else if (pos < POS_HI) begin
        running_crc_next = crc_fold;
        pos_next         = pos + POS_W'(1);
        res.valid        = 1'b1;
        res.kind         = xcrc_pkg::KIND_PAYLOAD;
        res.data_byte    = beat.rx_byte;
        res.byte_index   = pay_pos[6:0];
        res.verdict      = xcrc_pkg::V_GOOD;
      end else if (pos == POS_HI) begin
        crc_high_received_next = beat.rx_byte;
        pos_next               = pos + POS_W'(1);
      end else begin
        // crc low byte closes the packet
        close = 1'b1;
        if (err) begin
          v = xcrc_pkg::V_LINE;
        end else if (block_number == last_good_number + 8'd1) begin
          if (block_number + block_complement == xcrc_pkg::NUM_SUM &&
              crc_high_received == running_crc[15:8] &&
              beat.rx_byte == running_crc[7:0]) begin
            v                     = xcrc_pkg::V_GOOD;
            last_good_number_next = last_good_number + 8'd1;
          end else begin
            v = xcrc_pkg::V_BAD;
          end
        end else if (block_number == last_good_number) begin
          v = xcrc_pkg::V_DUP;
        end else begin
          v = xcrc_pkg::V_BAD;
        end
      end
    end
    if (close) begin
      pos_next         = '0;
      running_crc_next = '0;
      error_seen_next  = 1'b0;
      res.valid        = 1'b1;
      res.kind         = xcrc_pkg::KIND_VERDICT;
      res.verdict      = v;
      res.send_nak     = xcrc_pkg::nak_of(v);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos               <= '0;
      block_number      <= '0;
      block_complement  <= '0;
      running_crc       <= '0;
      crc_high_received <= '0;
      last_good_number  <= '0;
      error_seen        <= 1'b0;
    end else if (en) begin
      pos               <= pos_next;
      block_number      <= block_number_next;
      block_complement  <= block_complement_next;
      running_crc       <= running_crc_next;
      crc_high_received <= crc_high_received_next;
      last_good_number  <= last_good_number_next;
      error_seen        <= error_seen_next;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_MAX)
    else $error("packet position out of range");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    en && res.valid && res.kind == xcrc_pkg::KIND_VERDICT |=>
      pos == '0 && running_crc == '0)
    else $error("framing not restarted after verdict");

  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(last_good_number) |->
      last_good_number == $past(last_good_number) + 8'd1 && $past(en) &&
      $past(res.verdict) == xcrc_pkg::V_GOOD && $past(res.valid))
    else $error("sequence number moved without a good packet");

endmodule

[rtl/core/xmodem_crc_packet_receiver_top.sv]
// xmodem-crc packet receiver
// input channel s_*: one beat per uart byte or receive timeout event
//   (s_tuser = 1). every beat is consumed; bytes of an soh packet
//   (header, block number, complement, payload, crc high, crc low) are framed
//   internally.
// output channel m_*: m_tuser = 0 carries a payload byte with its index,
//   m_tuser = 1 carries the packet verdict and the ack/nak decision, given
//   on the closing crc byte, on a single-byte packet (eot or unknown header)
//   or on a timeout.
// path: a beat is held in the input register, then framing, crc fold and
//   verdict logic load the output register, which drives m_tvalid.
// throughput: one beat per cycle unless a result-bearing beat waits behind a
//   held output, set by the combinational bytewise crc fold and the framing state update.
// reset: rst (synchronous) clears framing, crc, error flag and last good
//   block number, and empties both registers.
// stall: while m_tready is low a waiting result holds; beats that give no
//   result still pass, and s_tready falls once a result-bearing beat is
//   waiting behind the held output.
module xmodem_crc_packet_receiver_top #(
  parameter int PAYLOAD_BYTES = xcrc_pkg::PAYLOAD_BYTES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [xcrc_pkg::IN_DATA_W-1:0]  s_tdata,  // rx_byte[7:0], rx_error[8], zero pad
  input  logic                            s_tuser,  // req_type[0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [xcrc_pkg::OUT_DATA_W-1:0] m_tdata,  // data_byte[7:0], byte_index[14:8],
                                                    // verdict[17:15], send_nak[18], zero pad
  output logic                            m_tuser   // result_kind[0]
);

  logic              in_valid;
  xcrc_pkg::beat_t   in_beat;
  logic              advance;
  logic              out_free;
  xcrc_pkg::result_t res;
  xcrc_pkg::result_t out_res;

  assign out_free = !out_res.valid || m_tready;
  // a beat without result may pass a held output; one with a result waits
  assign advance  = in_valid && (out_free || !res.valid);
  assign s_tready = !in_valid || advance;

  xcrc_framer #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_framer (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .beat (in_beat),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_beat.req_type <= s_tuser;
      in_beat.rx_byte  <= s_tdata[7:0];
      in_beat.rx_error <= s_tdata[8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_res.valid <= 1'b0;
    end else if (out_free) begin
      out_res.valid <= advance && res.valid;
    end
    if (out_free && advance && res.valid) begin
      out_res.kind       <= res.kind;
      out_res.data_byte  <= res.data_byte;
      out_res.byte_index <= res.byte_index;
      out_res.verdict    <= res.verdict;
      out_res.send_nak   <= res.send_nak;
    end
  end

  assign m_tvalid = out_res.valid;
  assign m_tuser  = out_res.kind;
  assign m_tdata  = {5'b0, out_res.send_nak, out_res.verdict, out_res.byte_index,
                     out_res.data_byte};

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_valid && !s_tready |-> m_tvalid && !m_tready && res.valid)
    else $error("input stalled without a blocked result");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("held result dropped");

  a_hold_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("held result changed");

endmodule

[dv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    xcrc_pkg::beat_t beat;
    bit              hold;  // sender waits for every outstanding result first
  } stim_t;

  typedef enum int {
    PKT_GOOD,
    PKT_DUP,
    PKT_BAD_NUM,
    PKT_BAD_CMP,
    PKT_BAD_CRC_HI,
    PKT_BAD_CRC_LO,
    PKT_LINE_ERR
  } pkt_kind_t;

  localparam int N_PKT_KINDS = 7;
  localparam int CALM_TAIL   = 120;

  logic                            clk      = 1'b0;
  logic                            rst      = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [xcrc_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
  logic                            s_tuser  = 1'b0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [xcrc_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                            m_tuser;

  stim_t             pending[$];
  xcrc_pkg::result_t expected_q[$];
  int                n_items    = 0;
  int                n_accepted = 0;
  int                n_pushed   = 0;
  int                n_seen     = 0;
  int                n_errors   = 0;
  bit                calm       = 1'b0;
  int                in_stall   = 0;
  int                in_run     = 0;
  int                out_stall  = 0;
  int                out_run    = 0;
  xcrc_pkg::beat_t   bus_beat;
  xcrc_pkg::result_t next_res;
  xcrc_pkg::result_t want;
  stim_t             next_stim;

  // receiver state as predicted
  int unsigned frame_pos = 0;
  logic [7:0]  hdr_byte  = '0;
  logic [7:0]  num_byte  = '0;
  logic [7:0]  cmp_byte  = '0;
  logic [7:0]  crc_hi_rx = '0;
  logic [7:0]  last_good = '0;
  logic [15:0] crc_acc   = '0;
  bit          line_err  = 1'b0;

  // stimulus side view of the sequence number
  logic [7:0]  gen_last = '0;
  bit          kind_seen[N_PKT_KINDS];

  always #5 clk = ~clk;

  xmodem_crc_packet_receiver_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] d);
    logic [15:0] c;
    c = crc ^ {d, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ xcrc_pkg::CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic int stretch_len();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
  endfunction

  function automatic void note_error(string msg);
    n_errors++;
    if (n_errors <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endfunction

  // verdict closes the frame and restarts framing, crc and error flag
  function automatic xcrc_pkg::result_t close_frame(xcrc_pkg::verdict_t v);
    xcrc_pkg::result_t r;
    r          = '0;
    r.valid    = 1'b1;
    r.kind     = xcrc_pkg::KIND_VERDICT;
    r.verdict  = v;
    r.send_nak = (v == xcrc_pkg::V_BAD || v == xcrc_pkg::V_LINE ||
                  v == xcrc_pkg::V_TIMEOUT);
    frame_pos  = 0;
    crc_acc    = '0;
    line_err   = 1'b0;
    return r;
  endfunction

  function automatic bit predict_beat(xcrc_pkg::beat_t b, output xcrc_pkg::result_t r);
    xcrc_pkg::verdict_t v;
    logic [7:0]         next_num;
    logic [8:0]         num_sum;
    bit                 got;
    r   = '0;
    got = 1'b0;
    if (b.req_type == xcrc_pkg::REQ_TIMEOUT) begin
      r   = close_frame(xcrc_pkg::V_TIMEOUT);
      got = 1'b1;
    end else begin
      if (b.rx_error) begin
        line_err = 1'b1;
      end
      if (frame_pos == 0) begin
        hdr_byte = b.rx_byte;
        if (b.rx_byte != xcrc_pkg::SOH_CODE) begin
          if (line_err) begin
            v = xcrc_pkg::V_LINE;
          end else if (b.rx_byte == xcrc_pkg::EOT_CODE) begin
            v = xcrc_pkg::V_END;
          end else begin
            v = xcrc_pkg::V_BAD;
          end
          r   = close_frame(v);
          got = 1'b1;
        end else begin
          frame_pos = 1;
        end
      end else if (frame_pos == 1) begin
        num_byte  = b.rx_byte;
        frame_pos = 2;
      end else if (frame_pos == 2) begin
        cmp_byte  = b.rx_byte;
        frame_pos = 3;
      end else if (frame_pos < xcrc_pkg::PAYLOAD_BYTES + 3) begin
        crc_acc      = crc16_byte(crc_acc, b.rx_byte);
        r.valid      = 1'b1;
        r.kind       = xcrc_pkg::KIND_PAYLOAD;
        r.data_byte  = b.rx_byte;
        r.byte_index = 7'(frame_pos - 3);
        frame_pos++;
        got = 1'b1;
      end else if (frame_pos == xcrc_pkg::PAYLOAD_BYTES + 3) begin
        crc_hi_rx = b.rx_byte;
        frame_pos++;
      end else begin
        // closing crc low byte
        next_num = last_good + 8'd1;
        num_sum  = {1'b0, num_byte} + {1'b0, cmp_byte};
        if (line_err) begin
          v = xcrc_pkg::V_LINE;
        end else if (num_byte == next_num) begin
          if (num_sum == {1'b0, xcrc_pkg::NUM_SUM} && crc_hi_rx == crc_acc[15:8] &&
              b.rx_byte == crc_acc[7:0]) begin
            v         = xcrc_pkg::V_GOOD;
            last_good = next_num;
          end else begin
            v = xcrc_pkg::V_BAD;
          end
        end else if (num_byte == last_good) begin
          v = xcrc_pkg::V_DUP;
        end else begin
          v = xcrc_pkg::V_BAD;
        end
        r   = close_frame(v);
        got = 1'b1;
      end
    end
    return got;
  endfunction

  task automatic add_beat(logic req, logic [7:0] v, bit e, bit hold = 1'b0);
    stim_t s;
    s.beat.req_type = req;
    s.beat.rx_byte  = v;
    s.beat.rx_error = e;
    s.hold          = hold;
    pending.push_back(s);
    n_items++;
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        bus_beat.req_type = s_tuser;
        bus_beat.rx_byte  = s_tdata[7:0];
        bus_beat.rx_error = s_tdata[8];
        if (predict_beat(bus_beat, next_res)) begin
          expected_q.push_back(next_res);
          n_pushed <= n_pushed + 1;
        end
        n_accepted <= n_accepted + 1;
      end
      calm <= pending.size() < CALM_TAIL;
      if (s_tvalid && !s_tready) begin
        // beat holds until taken
      end else if (pending.size() > 0 && pending[0].hold &&
                   (s_tvalid || n_pushed != n_seen)) begin
        s_tvalid <= 1'b0;
      end else if (pending.size() >= CALM_TAIL && (in_stall > 0 || in_run == 0)) begin
        s_tvalid <= 1'b0;
        if (in_stall == 0) begin
          in_stall = $urandom_range(1, 18);
        end
        in_stall--;
        if (in_stall == 0) begin
          in_run = stretch_len();
        end
      end else if (pending.size() > 0) begin
        if (in_run > 0) begin
          in_run--;
        end
        next_stim = pending.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= next_stim.beat.req_type;
        s_tdata  <= {{(xcrc_pkg::IN_DATA_W - 9){1'b0}}, next_stim.beat.rx_error,
                     next_stim.beat.rx_byte};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          note_error($sformatf("unexpected result: kind %0d tdata %h", m_tuser, m_tdata));
        end else begin
          want = expected_q.pop_front();
          if (m_tuser !== want.kind || m_tdata[7:0] !== want.data_byte ||
              m_tdata[14:8] !== want.byte_index || m_tdata[17:15] !== want.verdict ||
              m_tdata[18] !== want.send_nak) begin
            note_error($sformatf({"result %0d: expected kind %0d byte %h index %0d ",
                                  "verdict %0d nak %0d, got kind %0d byte %h index %0d ",
                                  "verdict %0d nak %0d"},
                                 n_seen, want.kind, want.data_byte, want.byte_index,
                                 want.verdict, want.send_nak, m_tuser, m_tdata[7:0],
                                 m_tdata[14:8], m_tdata[17:15], m_tdata[18]));
          end
          n_seen <= n_seen + 1;
        end
      end
      if (calm) begin
        m_tready <= 1'b1;
      end else if (out_stall > 0 || out_run == 0) begin
        m_tready <= 1'b0;
        if (out_stall == 0) begin
          out_stall = $urandom_range(1, 18);
        end
        out_stall--;
        if (out_stall == 0) begin
          out_run = stretch_len();
        end
      end else begin
        m_tready <= 1'b1;
        out_run--;
      end
    end
  end

  initial begin
    logic [7:0]  body[xcrc_pkg::PAYLOAD_BYTES];
    logic [7:0]  num;
    logic [7:0]  cmp;
    logic [7:0]  v;
    logic [15:0] crc;
    pkt_kind_t   k;
    int          r;
    int          err_at;
    int          n_cut;
    int          missing;
    bit          hold;

    // single-byte packets, timeouts, and restart after each verdict
    add_beat(xcrc_pkg::REQ_BYTE, xcrc_pkg::EOT_CODE, 1'b0);
    add_beat(xcrc_pkg::REQ_BYTE, 8'h00, 1'b0);
    add_beat(xcrc_pkg::REQ_BYTE, 8'hff, 1'b0);
    add_beat(xcrc_pkg::REQ_BYTE, 8'h02, 1'b1);
    add_beat(xcrc_pkg::REQ_BYTE, xcrc_pkg::EOT_CODE, 1'b1);
    add_beat(xcrc_pkg::REQ_TIMEOUT, 8'hff, 1'b1);
    add_beat(xcrc_pkg::REQ_BYTE, xcrc_pkg::SOH_CODE, 1'b0);
    add_beat(xcrc_pkg::REQ_BYTE, 8'h01, 1'b0);
    add_beat(xcrc_pkg::REQ_BYTE, 8'hfe, 1'b0);
    add_beat(xcrc_pkg::REQ_BYTE, 8'h00, 1'b0);
    add_beat(xcrc_pkg::REQ_BYTE, 8'hff, 1'b1);
    add_beat(xcrc_pkg::REQ_TIMEOUT, 8'h00, 1'b0);
    add_beat(xcrc_pkg::REQ_BYTE, xcrc_pkg::EOT_CODE, 1'b0);
    add_beat(xcrc_pkg::REQ_BYTE, xcrc_pkg::SOH_CODE, 1'b1);
    add_beat(xcrc_pkg::REQ_TIMEOUT, 8'h00, 1'b0);
    add_beat(xcrc_pkg::REQ_BYTE, xcrc_pkg::EOT_CODE, 1'b0);

    hold = 1'b1;
    do begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        // stray bytes and timeouts between packets
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 2))
            0: add_beat(xcrc_pkg::REQ_TIMEOUT, 8'($urandom), 1'($urandom_range(0, 1)),
                        hold);
            1: add_beat(xcrc_pkg::REQ_BYTE, xcrc_pkg::EOT_CODE, $urandom_range(0, 3) == 0,
                        hold);
            default: begin
              v = 8'($urandom);
              if (v == xcrc_pkg::SOH_CODE) begin
                v = xcrc_pkg::EOT_CODE;
              end
              add_beat(xcrc_pkg::REQ_BYTE, v, $urandom_range(0, 3) == 0, hold);
            end
          endcase
          hold = 1'b0;
        end
      end else if (r < 45) begin
        // packet cut short by a timeout
        n_cut = $urandom_range(0, 7) == 0 ? xcrc_pkg::PAYLOAD_BYTES + 3 :
                                            $urandom_range(0, 40);
        add_beat(xcrc_pkg::REQ_BYTE, xcrc_pkg::SOH_CODE, $urandom_range(0, 15) == 0, hold);
        for (int i = 0; i < n_cut; i++) begin
          add_beat(xcrc_pkg::REQ_BYTE, 8'($urandom), $urandom_range(0, 31) == 0);
        end
        add_beat(xcrc_pkg::REQ_TIMEOUT, 8'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        k = pkt_kind_t'($urandom_range(0, N_PKT_KINDS - 1));
        if ($urandom_range(0, 2) == 0) begin
          k = PKT_GOOD;
        end
        if (n_items > 500) begin
          foreach (kind_seen[i]) begin
            if (!kind_seen[i]) begin
              k = pkt_kind_t'(i);
            end
          end
        end
        crc = '0;
        for (int i = 0; i < xcrc_pkg::PAYLOAD_BYTES; i++) begin
          if ($urandom_range(0, 7) == 0) begin
            body[i] = $urandom_range(0, 1) ? 8'hff : 8'h00;
          end else begin
            body[i] = 8'($urandom);
          end
          crc = crc16_byte(crc, body[i]);
        end
        num    = gen_last + 8'd1;
        err_at = -1;
        case (k)
          PKT_GOOD:     gen_last = num;
          PKT_DUP:      num = gen_last;
          PKT_BAD_NUM:  num = gen_last + 8'($urandom_range(2, 255));
          PKT_LINE_ERR: err_at = $urandom_range(0, xcrc_pkg::PAYLOAD_BYTES + 4);
          default: ;
        endcase
        cmp = ~num;
        if (k == PKT_BAD_CMP) begin
          cmp ^= 8'($urandom_range(1, 255));
        end
        if (k == PKT_BAD_CRC_HI) begin
          crc[15:8] ^= 8'($urandom_range(1, 255));
        end
        if (k == PKT_BAD_CRC_LO) begin
          crc[7:0] ^= 8'($urandom_range(1, 255));
        end
        // a duplicate wins no matter what the rest holds
        if (k == PKT_DUP && $urandom_range(0, 1)) begin
          cmp = 8'($urandom);
          crc = 16'($urandom);
        end
        add_beat(xcrc_pkg::REQ_BYTE, xcrc_pkg::SOH_CODE, err_at == 0, hold);
        add_beat(xcrc_pkg::REQ_BYTE, num, err_at == 1);
        add_beat(xcrc_pkg::REQ_BYTE, cmp, err_at == 2);
        for (int i = 0; i < xcrc_pkg::PAYLOAD_BYTES; i++) begin
          add_beat(xcrc_pkg::REQ_BYTE, body[i], err_at == i + 3);
        end
        add_beat(xcrc_pkg::REQ_BYTE, crc[15:8], err_at == xcrc_pkg::PAYLOAD_BYTES + 3);
        add_beat(xcrc_pkg::REQ_BYTE, crc[7:0], err_at == xcrc_pkg::PAYLOAD_BYTES + 4);
        kind_seen[k] = 1'b1;
      end
      hold    = $urandom_range(0, 9) == 0;
      missing = 0;
      foreach (kind_seen[i]) begin
        if (!kind_seen[i]) begin
          missing++;
        end
      end
    end while (n_items < 4000 && (n_items < 800 || missing > 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (n_accepted != n_items) @(posedge clk);
    while (n_pushed != n_seen) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[xmodem_crc_packet_receiver_top.f]
rtl/core/xcrc_pkg.sv
rtl/core/xcrc_crc16.sv
rtl/core/xcrc_framer.sv
rtl/core/xmodem_crc_packet_receiver_top.sv
dv/tb.sv
